>>> rtl/core/i2cms_pkg.sv
// Shared types and constants of the I2C master transfer sequencer.
package i2cms_pkg;

   // Longest transfer in bytes accepted by a start
   localparam int unsigned MAX_BYTES = 255;

   // Configuration register indexes
   localparam logic [7:0] CSR_TIMEOUT_TICKS = 8'd0;
   localparam logic [7:0] CSR_RESET_LIMIT   = 8'd1;

   // Reset values of the configuration registers
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
   localparam logic [7:0]  RESET_LIMIT_RST   = 8'd10;

   // Event bits, same order as bus_status
   localparam logic [3:0] EV_NACK = 4'b0001;
   localparam logic [3:0] EV_RX   = 4'b0010;
   localparam logic [3:0] EV_TX   = 4'b0100;
   localparam logic [3:0] EV_TXC  = 4'b1000;

   typedef enum logic [2:0] {
      OP_START_READ  = 3'd0,
      OP_START_WRITE = 3'd1,
      OP_STATUS      = 3'd2,
      OP_TICK        = 3'd3,
      OP_CLEAR       = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      OUT_PENDING     = 3'd0,
      OUT_SUCCESS     = 3'd1,
      OUT_NACK        = 3'd2,
      OUT_INVALID     = 3'd3,
      OUT_BUSY        = 3'd4,
      OUT_TIMEOUT     = 3'd5,
      OUT_DEACTIVATED = 3'd6
   } outcome_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  byte_count;
      logic [6:0]  device_address;
      logic [1:0]  sub_address_size;
      logic [23:0] sub_address;
      logic [3:0]  bus_status;
      logic [7:0]  received_byte;
      logic [7:0]  next_send_byte;
   } item_type;

   typedef struct packed {
      outcome_type outcome;
      logic        in_progress;
      logic        read_valid;
      logic [7:0]  read_data;
      logic        send_valid;
      logic [7:0]  send_data;
      logic        issue_stop;
      logic        issue_start;
      logic        read_mode;
      logic [6:0]  device_address_out;
      logic [1:0]  sub_address_size_out;
      logic [23:0] sub_address_out;
   } result_type;

   typedef struct packed {
      logic [7:0]  bytes_left_rx;
      logic [7:0]  bytes_left_tx;
      logic [3:0]  event_mask;
      logic [24:0] ticks_left;
      logic [7:0]  reset_count;
      logic        deactivated;
   } state_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  reset_limit;
   } cfg_type;

endpackage

>>> rtl/core/i2cms_step.sv
// Next-state and result logic for one sequencer item.
module i2cms_step (
   input  i2cms_pkg::item_type   item,
   input  i2cms_pkg::state_type  cur,
   input  i2cms_pkg::cfg_type    cfg,
   output i2cms_pkg::state_type  nxt,
   output i2cms_pkg::result_type res
);

   logic        busy;
   logic [3:0]  events;
   logic [8:0]  rc_plus;
   logic [24:0] budget;
   logic [7:0]  rc_fail;
   logic [7:0]  rc_ok;
   logic        len_bad;

   // Shared terms
   assign busy    = (cur.bytes_left_rx != 8'd0) || (cur.bytes_left_tx != 8'd0);
   assign events  = item.bus_status & cur.event_mask;
   assign rc_plus = {1'b0, cur.reset_count} + 9'd1;
   assign budget  = 25'(cfg.timeout_ticks) * 25'(rc_plus);
   assign rc_fail = (cur.reset_count != 8'hFF) ? rc_plus[7:0] : cur.reset_count;
   assign rc_ok   = (cur.reset_count != 8'd0) ? cur.reset_count - 8'd1 : cur.reset_count;
   assign len_bad = (item.byte_count == 8'd0) || (32'(item.byte_count) > i2cms_pkg::MAX_BYTES);

   always_comb begin
      nxt = cur;
      res = '0;

      unique case (item.opcode)
         i2cms_pkg::OP_START_READ, i2cms_pkg::OP_START_WRITE: begin
            if (cur.deactivated) begin
               res.outcome = i2cms_pkg::OUT_DEACTIVATED;
            end else if (len_bad || busy) begin
               // invalid length or transfer still running: error path
               res.outcome    = len_bad ? i2cms_pkg::OUT_INVALID : i2cms_pkg::OUT_BUSY;
               res.issue_stop = 1'b1;
               nxt.reset_count = rc_fail;
               if (rc_fail > cfg.reset_limit) nxt.deactivated = 1'b1;
               nxt.bytes_left_rx = '0;
               nxt.bytes_left_tx = '0;
               nxt.event_mask    = '0;
               nxt.ticks_left    = '0;
            end else begin
               nxt.ticks_left           = budget;
               res.issue_start          = 1'b1;
               res.device_address_out   = item.device_address;
               res.sub_address_size_out = item.sub_address_size;
               res.sub_address_out      = item.sub_address;
               if (item.opcode == i2cms_pkg::OP_START_READ) begin
                  nxt.bytes_left_rx = item.byte_count;
                  nxt.bytes_left_tx = '0;
                  nxt.event_mask    = i2cms_pkg::EV_NACK | i2cms_pkg::EV_RX;
                  res.read_mode     = 1'b1;
                  res.issue_stop    = (item.byte_count == 8'd1);
               end else begin
                  nxt.bytes_left_tx = item.byte_count;
                  nxt.bytes_left_rx = '0;
                  nxt.event_mask    = i2cms_pkg::EV_NACK | i2cms_pkg::EV_TX;
                  res.send_valid    = 1'b1;
                  res.send_data     = item.next_send_byte;
               end
            end
         end

         i2cms_pkg::OP_STATUS: begin
            // priority: nack, rx ready, tx ready, tx complete
            if ((events & i2cms_pkg::EV_NACK) != 4'd0) begin
               res.outcome     = i2cms_pkg::OUT_NACK;
               res.issue_stop  = 1'b1;
               nxt.reset_count = rc_fail;
               if (rc_fail > cfg.reset_limit) nxt.deactivated = 1'b1;
               nxt.bytes_left_rx = '0;
               nxt.bytes_left_tx = '0;
               nxt.event_mask    = '0;
               nxt.ticks_left    = '0;
            end else if ((events & i2cms_pkg::EV_RX) != 4'd0) begin
               res.read_valid = 1'b1;
               res.read_data  = item.received_byte;
               if (cur.bytes_left_rx != 8'd0) begin
                  nxt.bytes_left_rx = cur.bytes_left_rx - 8'd1;
                  // stop goes out ahead of the last byte
                  res.issue_stop = (cur.bytes_left_rx == 8'd2);
                  if (cur.bytes_left_rx == 8'd1) begin
                     nxt.event_mask  = '0;
                     res.outcome     = i2cms_pkg::OUT_SUCCESS;
                     nxt.reset_count = rc_ok;
                  end
               end
            end else if ((events & i2cms_pkg::EV_TX) != 4'd0) begin
               if (cur.bytes_left_tx <= 8'd1) begin
                  nxt.bytes_left_tx = '0;
                  nxt.event_mask    = i2cms_pkg::EV_TXC;
                  res.outcome       = i2cms_pkg::OUT_SUCCESS;
                  nxt.reset_count   = rc_ok;
               end else begin
                  nxt.bytes_left_tx = cur.bytes_left_tx - 8'd1;
                  res.send_valid    = 1'b1;
                  res.send_data     = item.next_send_byte;
               end
            end else if ((events & i2cms_pkg::EV_TXC) != 4'd0) begin
               nxt.event_mask = '0;
            end
         end

         i2cms_pkg::OP_TICK: begin
            if (busy) begin
               if (cur.ticks_left == 25'd0) begin
                  res.outcome     = i2cms_pkg::OUT_TIMEOUT;
                  res.issue_stop  = 1'b1;
                  nxt.reset_count = rc_fail;
                  if (rc_fail > cfg.reset_limit) nxt.deactivated = 1'b1;
                  nxt.bytes_left_rx = '0;
                  nxt.bytes_left_tx = '0;
                  nxt.event_mask    = '0;
                  nxt.ticks_left    = '0;
               end else begin
                  nxt.ticks_left = cur.ticks_left - 25'd1;
               end
            end
         end

         i2cms_pkg::OP_CLEAR: begin
            res.issue_stop    = 1'b1;
            nxt.bytes_left_rx = '0;
            nxt.bytes_left_tx = '0;
            nxt.event_mask    = '0;
            nxt.ticks_left    = '0;
         end

         default: ;
      endcase

      res.in_progress = (nxt.bytes_left_rx != 8'd0) || (nxt.bytes_left_tx != 8'd0);
   end

endmodule

>>> rtl/core/i2c_master_transfer_sequencer_core.sv
// A request beat passes the input register, then the result register, before rsp offers
// it. Throughput: one beat per cycle unless rsp stalls; one step stage advances state per beat.
// While a result waits on rsp, the input register holds one more beat, then req_tready drops
// until the result is taken.
// Reset (synchronous, active high): transfer cleared, all events masked, reset count zero,
// timeout_ticks 100, reset_limit 10; the block is ready the cycle after reset drops.
module i2c_master_transfer_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: byte_count[7:0], device_address[14:8], sub_address_size[16:15],
   //        sub_address[40:17], bus_status[44:41], received_byte[52:45],
   //        next_send_byte[60:53], zero[63:61]
   input  logic [63:0] req_tdata,
   // tuser: opcode[2:0]
   input  logic [2:0]  req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: in_progress[0], read_data[8:1], send_data[16:9], issue_stop[17],
   //        issue_start[18], read_mode[19], device_address_out[26:20],
   //        sub_address_size_out[28:27], sub_address_out[52:29], zero[55:53]
   output logic [55:0] rsp_tdata,
   // tuser: outcome[2:0], read_valid[3], send_valid[4]
   output logic [4:0]  rsp_tuser,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                  in_valid_ff;
   i2cms_pkg::item_type   in_item_ff;
   logic                  out_valid_ff;
   i2cms_pkg::result_type out_res_ff;
   i2cms_pkg::state_type  state_ff;
   i2cms_pkg::state_type  state_in;
   i2cms_pkg::result_type res_in;
   i2cms_pkg::cfg_type    cfg_ff;
   i2cms_pkg::item_type   req_item;
   logic                  advance;

   // Unpack the request beat
   assign req_item.opcode           = req_tuser;
   assign req_item.byte_count       = req_tdata[7:0];
   assign req_item.device_address   = req_tdata[14:8];
   assign req_item.sub_address_size = req_tdata[16:15];
   assign req_item.sub_address      = req_tdata[40:17];
   assign req_item.bus_status       = req_tdata[44:41];
   assign req_item.received_byte    = req_tdata[52:45];
   assign req_item.next_send_byte   = req_tdata[60:53];

   // Handshakes
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   i2cms_step u_step (
      .item (in_item_ff),
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   // Transfer state, advanced once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= i2cms_pkg::TIMEOUT_TICKS_RST;
         cfg_ff.reset_limit   <= i2cms_pkg::RESET_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            i2cms_pkg::CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            i2cms_pkg::CSR_RESET_LIMIT:   cfg_ff.reset_limit   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Pack the response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_res_ff.send_valid, out_res_ff.read_valid, out_res_ff.outcome};
   assign rsp_tdata  = {3'b000,
                        out_res_ff.sub_address_out,
                        out_res_ff.sub_address_size_out,
                        out_res_ff.device_address_out,
                        out_res_ff.read_mode,
                        out_res_ff.issue_start,
                        out_res_ff.issue_stop,
                        out_res_ff.send_data,
                        out_res_ff.read_data,
                        out_res_ff.in_progress};

endmodule
